@@ rtl/cmf_pkg.sv @@
// cross mean filter package: widths, register codes, result type and helpers
// no dependencies; used by the interfaces, all rtl modules and the checker
package cmf_pkg;

    localparam int PIX_W       = 8;
    localparam int COORD_W     = 10;
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_LINES_DEF = 1024;
    localparam int WIDTH_RESET = 640;
    localparam int LINES_RESET = 480;
    localparam int MIN_DIM     = 3;

    localparam int SUM_W       = 11;
    localparam int DIV5_MUL_W  = 14;
    localparam int DIV5_SHIFT  = 16;
    localparam int PROD_W      = SUM_W + DIV5_MUL_W;
    localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 14'd13108;

    typedef logic [PIX_W-1:0]     t_pix;
    typedef logic [COORD_W-1:0]   t_coord;
    typedef logic [CFG_W-1:0]     t_cfg_data;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_WIDTH = 2'd0,
        REG_LINE_COUNT = 2'd1
    } t_reg_idx;

    typedef struct packed {
        t_pix up;
        t_pix left;
        t_pix centre;
        t_pix right;
        t_pix down;
    } t_cross;

    typedef struct packed {
        t_coord out_row;
        t_coord out_column;
        t_pix   pixel_out;
        logic   frame_last;
    } t_result;

    // saturate a size register into [MIN_DIM, hi]
    function automatic int clamp_dim(input t_cfg_data v, input int hi);
        int x;
        x = int'(v);
        if (x < MIN_DIM) begin
            return MIN_DIM;
        end
        if (x > hi) begin
            return hi;
        end
        return x;
    endfunction

endpackage

@@ rtl/cmf_if.sv @@
// cross mean filter channels: pixel input, result output and register write
// depends on cmf_pkg
interface cmf_pix_if;
    logic          valid;
    logic          ready;
    cmf_pkg::t_pix pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface cmf_res_if;
    logic            valid;
    logic            ready;
    cmf_pkg::t_coord out_row;
    cmf_pkg::t_coord out_column;
    cmf_pkg::t_pix   pixel_out;
    logic            frame_last;

    modport source (output valid, output out_row, output out_column, output pixel_out,
                    output frame_last, input ready);
    modport sink   (input valid, input out_row, input out_column, input pixel_out,
                    input frame_last, output ready);
endinterface

interface cmf_cfg_if;
    logic               valid;
    logic               ready;
    cmf_pkg::t_cfg_idx  index;
    cmf_pkg::t_cfg_data data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/cmf_line_buf.sv @@
// cross mean filter line buffers: rows r-1 and r-2, registered reads
// depends on cmf_pkg
module cmf_line_buf #(
    parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  cmf_pkg::t_pix                i_pix,
    input  logic                         i_wb_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wb_addr,
    output cmf_pkg::t_pix                o_up1,
    output cmf_pkg::t_pix                o_right,
    output cmf_pkg::t_pix                o_up2
);
    import cmf_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    t_pix r_above     [MAX_WIDTH];
    t_pix r_two_above [MAX_WIDTH];
    t_pix r_up1;
    t_pix r_right;
    t_pix r_up2;

    // row r-1: read centre and right, store the new pixel in the same beat
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up1                <= r_above[i_rd_addr];
            r_right              <= r_above[AW'(i_rd_addr + 1'b1)];
            r_up2                <= r_two_above[i_rd_addr];
            r_above[i_rd_addr]   <= i_pix;
        end
    end

    // row r-2: old row r-1 value moves down in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (i_wb_en) begin
            r_two_above[i_wb_addr] <= r_up1;
        end
    end

    assign o_up1   = r_up1;
    assign o_right = r_right;
    assign o_up2   = r_up2;

endmodule

@@ rtl/cmf_mean5.sv @@
// cross mean filter arithmetic: truncated mean of five pixels
// depends on cmf_pkg
module cmf_mean5 (
    input  cmf_pkg::t_cross i_cross,
    output cmf_pkg::t_pix   o_mean
);
    import cmf_pkg::*;

    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;

    always_comb begin
        sum = SUM_W'(i_cross.up) + SUM_W'(i_cross.left) + SUM_W'(i_cross.centre)
            + SUM_W'(i_cross.right) + SUM_W'(i_cross.down);
        // divide by 5 through reciprocal, exact for sums up to 5 * 255
        prod   = PROD_W'(sum) * PROD_W'(DIV5_MUL);
        o_mean = prod[DIV5_SHIFT +: PIX_W];
    end

endmodule

@@ rtl/cross_mean_filter_3x3.sv @@
// cross mean filter top level: counters, work stage, output register, registers
// depends on cmf_pkg, cmf_if, cmf_line_buf, cmf_mean5
//
// Five-point mean filter over a raster stream of 8-bit pixels. A pixel is taken
// in every clock unless stalled; the result for centre (r-1,c) of pixel (r,c)
// passes the work stage and a single output register. Pixels of the last row
// also leave unchanged as a second result, so there a pixel is taken only once
// both results of the one before have left the work stage. Pixels of the first
// row give no result. Border centres pass unchanged; the final result of a
// frame carries frame_last. Line width and line count are saturated into
// [3, MAX] on write and take effect at the next pixel. The line buffers have
// no reset and no clearing pass; the first two rows of a frame fill them.
module cross_mean_filter_3x3 #(
    parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_LINES = cmf_pkg::MAX_LINES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    cmf_pix_if.sink   i_pix,
    cmf_res_if.source o_res,
    cmf_cfg_if.sink   i_cfg
);
    import cmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_LINES);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_LINES + 1);

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_lines;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    logic          r_s1_valid;
    logic          r_s1_phase;
    logic          r_s1_has_a;
    logic          r_s1_has_b;
    logic          r_s1_interior;
    logic          r_s1_last;
    logic [RW-1:0] r_s1_row;
    logic [CW-1:0] r_s1_col;
    t_pix          r_s1_pix;
    t_pix          r_s1_left;
    logic          r_wb_en;

    logic          r_out_valid;
    t_result       r_out;
    t_result       n_out;

    logic          accept;
    logic          last_col;
    logic          last_row;
    logic          interior;
    logic          emit_a;
    logic          emit_b;
    logic          res_valid;
    logic          res_last;
    logic          out_load;
    logic          xfer;
    logic          s1_done;
    t_pix          up1;
    t_pix          right;
    t_pix          up2;
    t_pix          mean;
    t_cross        cross_pix;

    cmf_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
        .i_clk    (i_clk),
        .i_rd_en  (accept),
        .i_rd_addr(r_col),
        .i_pix    (i_pix.pixel_in),
        .i_wb_en  (r_wb_en),
        .i_wb_addr(r_s1_col),
        .o_up1    (up1),
        .o_right  (right),
        .o_up2    (up2)
    );

    assign cross_pix = '{up: up2, left: r_s1_left, centre: up1, right: right, down: r_s1_pix};

    cmf_mean5 u_mean5 (
        .i_cross(cross_pix),
        .o_mean (mean)
    );

    // position of the arriving pixel
    always_comb begin
        last_col = WW'(r_col) >= r_width - 1'b1;
        last_row = HW'(r_row) >= r_lines - 1'b1;
        interior = (r_row >= RW'(2)) && (HW'(r_row) < r_lines)
                && (r_col != '0) && !last_col;
    end

    // work stage hands out the centre result, then the pass-through one
    always_comb begin
        emit_a    = r_s1_has_a && !r_s1_phase;
        emit_b    = r_s1_has_b && (r_s1_phase || !r_s1_has_a);
        res_valid = r_s1_valid && (emit_a || emit_b);
        res_last  = emit_b || !r_s1_has_b;
        out_load  = !r_out_valid || o_res.ready;
        xfer      = res_valid && out_load;
        s1_done   = r_s1_valid && (!(emit_a || emit_b) || (xfer && res_last));
    end

    assign i_pix.ready = !r_s1_valid || s1_done;
    assign accept      = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (emit_a) begin
            n_out.out_row    = COORD_W'(r_s1_row - 1'b1);
            n_out.out_column = COORD_W'(r_s1_col);
            n_out.pixel_out  = r_s1_interior ? mean : up1;
            n_out.frame_last = 1'b0;
        end else begin
            n_out.out_row    = COORD_W'(r_s1_row);
            n_out.out_column = COORD_W'(r_s1_col);
            n_out.pixel_out  = r_s1_pix;
            n_out.frame_last = r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WW'(clamp_dim(t_cfg_data'(WIDTH_RESET), MAX_WIDTH));
            r_lines     <= HW'(clamp_dim(t_cfg_data'(LINES_RESET), MAX_LINES));
            r_col       <= '0;
            r_row       <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_phase  <= 1'b0;
            r_wb_en     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (t_reg_idx'(i_cfg.index))
                    REG_LINE_WIDTH: r_width <= WW'(clamp_dim(i_cfg.data, MAX_WIDTH));
                    REG_LINE_COUNT: r_lines <= HW'(clamp_dim(i_cfg.data, MAX_LINES));
                    default: ;
                endcase
            end
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : RW'(r_row + 1'b1);
                end else begin
                    r_col <= CW'(r_col + 1'b1);
                end
            end
            r_wb_en <= accept;
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_s1_phase <= 1'b0;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end else if (xfer) begin
                r_s1_phase <= 1'b1;
            end
            if (xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_has_a    <= r_row != '0;
            r_s1_has_b    <= last_row;
            r_s1_interior <= interior;
            r_s1_last     <= last_col;
            r_s1_row      <= r_row;
            r_s1_col      <= r_col;
            r_s1_pix      <= i_pix.pixel_in;
            // previous beat's row r-1 value is the left neighbor
            r_s1_left     <= up1;
        end
        if (xfer) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_row    = r_out.out_row;
    assign o_res.out_column = r_out.out_column;
    assign o_res.pixel_out  = r_out.pixel_out;
    assign o_res.frame_last = r_out.frame_last;

endmodule

@@ rtl/cmf_check.sv @@
// cross mean filter checker: port-level assertions, bound to the top level
// depends on cmf_pkg and cross_mean_filter_3x3
module cmf_check (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input cmf_pkg::t_coord i_out_row,
    input cmf_pkg::t_coord i_out_col,
    input cmf_pkg::t_pix   i_out_pix,
    input logic            i_out_last
);
    import cmf_pkg::*;

    // stalled result keeps its beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_row) && $stable(i_out_col)
            && $stable(i_out_pix) && $stable(i_out_last))
        else $error("result payload changed while stalled");

    // input held off only while results are queued
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |=> i_out_valid)
        else $error("input stalled with no result on the way");

    // a fresh result stems from an earlier pixel beat held in the work stage
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result appeared without a pixel beat");

endmodule

bind cross_mean_filter_3x3 cmf_check u_cmf_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_pix.valid),
    .i_in_ready (i_pix.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_out_row  (o_res.out_row),
    .i_out_col  (o_res.out_column),
    .i_out_pix  (o_res.pixel_out),
    .i_out_last (o_res.frame_last)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for cross_mean_filter_3x3: a directed table of small frames, then random frames
// with random pixel and result stalls; each result beat is checked against a local predictor
// depends on cmf_pkg, the channel interfaces in cmf_if and the filter rtl
module tb_top;
    import cmf_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int MAX_H         = MAX_LINES_DEF;
    localparam int RAND_ITEMS    = 650;
    localparam int WIDE_PIXELS   = 40;
    localparam int TALL_PIXELS   = 90;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int LONG_HOLD     = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_REPORTS   = 40;

    typedef enum logic {
        STEP_CFG,
        STEP_PIX
    } t_step_kind;

    typedef struct packed {
        t_step_kind kind;
        t_reg_idx   idx;
        t_cfg_data  val;
        logic       typed;
        t_pix       want;
    } t_dir_step;

    // typed values apply to the first result beat of the pixel
    localparam int DIR_LEN = 26;
    localparam t_dir_step DIR_TAB [DIR_LEN] = '{
        '{STEP_CFG, REG_LINE_WIDTH, 11'd0,   1'b0, 8'd0},
        '{STEP_CFG, REG_LINE_COUNT, 11'd1,   1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd0,   1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd7,   1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd1,   1'b1, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd254, 1'b1, 8'd255},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b1, 8'd7},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd200, 1'b1, 8'd1},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd3,   1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd9,   1'b1, 8'd255},
        '{STEP_CFG, REG_LINE_WIDTH, 11'd4,   1'b0, 8'd0},
        '{STEP_CFG, REG_LINE_COUNT, 11'd4,   1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b1, 8'd255},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b1, 8'd255},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b1, 8'd255},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b1, 8'd255},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b1, 8'd255},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd255, 1'b1, 8'd255},
        '{STEP_CFG, REG_LINE_WIDTH, 11'd3,   1'b0, 8'd0},
        '{STEP_CFG, REG_LINE_COUNT, 11'd3,   1'b0, 8'd0},
        '{STEP_PIX, REG_LINE_WIDTH, 11'd0,   1'b1, 8'd255}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    cmf_pix_if pix_ch ();
    cmf_res_if res_ch ();
    cmf_cfg_if cfg_ch ();

    cross_mean_filter_3x3 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // predictor state
    t_cfg_data   width_reg = t_cfg_data'(WIDTH_RESET);
    t_cfg_data   lines_reg = t_cfg_data'(LINES_RESET);
    t_pix        prev_row  [MAX_W];
    t_pix        prev_row2 [MAX_W];
    int unsigned next_row = 0;
    int unsigned next_col = 0;
    t_result     pending_results [$];

    int          err_cnt = 0;
    int unsigned pixels_sent = 0;
    int          hold_asks = 0;
    bit          tx_fast = 1'b0;
    int          idle_cycles = 0;

    function automatic int unsigned sat_dim(input t_cfg_data raw, input int unsigned top);
        if (raw < MIN_DIM) begin
            return MIN_DIM;
        end
        if (raw > top) begin
            return top;
        end
        return raw;
    endfunction

    function automatic void filter_pixel(input t_pix p, input logic typed, input t_pix want);
        int unsigned w, h, r, c, sum;
        t_pix        up1, up2;
        t_result     beat;
        w   = sat_dim(width_reg, MAX_W);
        h   = sat_dim(lines_reg, MAX_H);
        r   = next_row;
        c   = next_col;
        up1 = prev_row[c];
        up2 = prev_row2[c];
        if (r >= 1) begin
            beat.out_row    = t_coord'(r - 1);
            beat.out_column = t_coord'(c);
            beat.pixel_out  = up1;
            beat.frame_last = 1'b0;
            if (r - 1 >= 1 && r - 1 < h - 1 && c >= 1 && c < w - 1) begin
                // left neighbour of row r-1 has already moved into the older buffer
                sum = int'(up2) + int'(p) + int'(prev_row2[c - 1]) + int'(up1)
                    + int'(prev_row[c + 1]);
                beat.pixel_out = t_pix'(sum / 5);
            end
            if (typed) begin
                beat.pixel_out = want;
            end
            pending_results.push_back(beat);
        end
        if (r >= h - 1) begin
            beat.out_row    = t_coord'(r);
            beat.out_column = t_coord'(c);
            beat.pixel_out  = p;
            beat.frame_last = (c >= w - 1);
            pending_results.push_back(beat);
        end
        prev_row2[c] = up1;
        prev_row[c]  = p;
        if (c >= w - 1) begin
            next_col = 0;
            next_row = (r >= h - 1) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
        end
    endfunction

    function automatic int pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            return 0;
        end
        if (sel < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_pix rand_pixel();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            return 8'h00;
        end
        if (sel == 1) begin
            return 8'hFF;
        end
        return t_pix'($urandom_range(0, 255));
    endfunction

    function automatic t_cfg_data rand_width();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return t_cfg_data'($urandom_range(0, 2));
        end
        if (sel == 1) begin
            return t_cfg_data'($urandom_range(13, 40));
        end
        return t_cfg_data'($urandom_range(3, 12));
    endfunction

    function automatic t_cfg_data rand_lines();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return t_cfg_data'($urandom_range(0, 2));
        end
        if (sel == 1) begin
            return t_cfg_data'($urandom_range(9, 20));
        end
        return t_cfg_data'($urandom_range(3, 8));
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            if (err_cnt < MAX_REPORTS) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
            err_cnt++;
        end
    endfunction

    task automatic push_pixel(input t_pix p, input logic typed, input t_pix want);
        int gap;
        gap = tx_fast ? 0 : pick_gap();
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.pixel_in <= p;
        do @(posedge i_clk); while (!pix_ch.ready);
        filter_pixel(p, typed, want);
        pixels_sent++;
    endtask

    task automatic finish_frame();
        do push_pixel(rand_pixel(), 1'b0, 8'd0); while (next_row != 0 || next_col != 0);
    endtask

    task automatic send_frames(input int unsigned n);
        repeat (n) finish_frame();
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input t_cfg_data val);
        pix_ch.valid <= 1'b0;
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_LINE_WIDTH) begin
            width_reg = val;
        end else begin
            lines_reg = val;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_results.size() == 0) begin
                if (err_cnt < MAX_REPORTS) begin
                    $display("%0t: unexpected beat: expected none, actual row %0d col %0d pix %0d",
                             $time, res_ch.out_row, res_ch.out_column, res_ch.pixel_out);
                end
                err_cnt++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_row", want.out_row, res_ch.out_row);
                check_field("out_column", want.out_column, res_ch.out_column);
                check_field("pixel_out", want.pixel_out, res_ch.pixel_out);
                check_field("frame_last", want.frame_last, res_ch.frame_last);
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result receiver: random stalls, full-rate bursts and requested long holds
    initial begin : result_sink
        int stall_left;
        int burst_left;
        int hold_seen;
        stall_left   = 0;
        burst_left   = 0;
        hold_seen    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_asks) begin
                hold_seen    = hold_asks;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (burst_left > 0) begin
                burst_left--;
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b1;
                if ($urandom_range(0, 15) == 0) begin
                    burst_left = $urandom_range(20, 120);
                end else if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_step   s;
        int          k;
        int unsigned base, cut, frame_px, sel;
        bit          first_phase;
        pix_ch.valid    = 1'b0;
        pix_ch.pixel_in = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_LINE_WIDTH;
        cfg_ch.data     = '0;
        i_rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_LEN; k++) begin
            s = DIR_TAB[k];
            if (s.kind == STEP_CFG) begin
                write_reg(s.idx, s.val);
            end else begin
                push_pixel(s.val[PIX_W-1:0], s.typed, s.want);
            end
        end

        // oversized width saturates; a narrow width then closes the first row early
        write_reg(REG_LINE_WIDTH, 11'd2047);
        write_reg(REG_LINE_COUNT, 11'd3);
        repeat (WIDE_PIXELS) push_pixel(rand_pixel(), 1'b0, 8'd0);
        write_reg(REG_LINE_WIDTH, 11'd3);
        finish_frame();
        // oversized count saturates; input held back by a long receiver hold
        write_reg(REG_LINE_COUNT, 11'd2047);
        tx_fast = 1'b1;
        hold_asks++;
        repeat (TALL_PIXELS) push_pixel(rand_pixel(), 1'b0, 8'd0);
        tx_fast = 1'b0;
        write_reg(REG_LINE_COUNT, 11'd3);
        finish_frame();

        base        = pixels_sent;
        first_phase = 1'b1;
        while (pixels_sent - base < RAND_ITEMS) begin
            sel = first_phase ? 2 : $urandom_range(0, 3);
            if (sel != 1) begin
                write_reg(REG_LINE_WIDTH, rand_width());
            end
            if (sel != 0) begin
                write_reg(REG_LINE_COUNT, rand_lines());
            end
            tx_fast = first_phase || ($urandom_range(0, 3) == 0);
            if (first_phase) begin
                hold_asks++;
            end
            first_phase = 1'b0;
            if ($urandom_range(0, 4) == 0) begin
                // shrink width and move the last row while inside a frame
                frame_px = sat_dim(width_reg, MAX_W) * sat_dim(lines_reg, MAX_H);
                cut      = $urandom_range(1, frame_px - 1);
                repeat (cut) push_pixel(rand_pixel(), 1'b0, 8'd0);
                write_reg(REG_LINE_WIDTH,
                          t_cfg_data'($urandom_range(0, sat_dim(width_reg, MAX_W))));
                write_reg(REG_LINE_COUNT, rand_lines());
                finish_frame();
            end
            send_frames($urandom_range(1, 3));
        end

        pix_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
